// ----- sv/mtp_pkg.sv -----
// ----------------------------------------------------------------------------
// mtp_pkg
// Types, codes and constants shared by the MAC address text parser modules.
// ----------------------------------------------------------------------------
package mtp_pkg;

    localparam int CHAR_W       = 8;
    localparam int NIBBLE_W     = 4;
    localparam int ADDR_W       = 48;
    localparam int PART_W       = 3;
    localparam int DIGIT_W      = 2;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [PART_W-1:0]   LAST_PART       = 3'd5;
    localparam logic [DIGIT_W-1:0]  DIGITS_PER_PART = 2'd2;

    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
    localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UF    = 8'h46;
    localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h66;

    typedef enum logic [2:0] {
        CLS_HEX,
        CLS_BLANK,
        CLS_COLON,
        CLS_DASH,
        CLS_OTHER
    } char_class_t;

    typedef enum logic [1:0] {
        PH_LEAD,
        PH_START,
        PH_PART,
        PH_TRAIL
    } phase_t;

    typedef enum logic [1:0] {
        SEP_NONE,
        SEP_COLON,
        SEP_DASH
    } sep_kind_t;

    typedef enum logic [2:0] {
        ERR_NONE,
        ERR_NO_DIGIT,
        ERR_TOO_MANY,
        ERR_MIXED_SEP,
        ERR_TRAILING,
        ERR_UNEXPECTED,
        ERR_PART_COUNT,
        ERR_LAST_DIGITS
    } err_code_t;

    // One classified character as it travels from front to back.
    typedef struct packed {
        logic                ends;     // item closes the string
        logic                no_char;  // no character to consume
        char_class_t         cls;
        logic [NIBBLE_W-1:0] nibble;
    } mtp_item_t;

endpackage

// ----- sv/mtp_classify.sv -----
// ----------------------------------------------------------------------------
// mtp_classify
// Front end: sorts each incoming character into a class and hex value.
// ----------------------------------------------------------------------------
module mtp_classify
    import mtp_pkg::*;
(
    input  logic [CHAR_W-1:0] character,
    input  logic              is_last,
    input  logic              end_only,
    output mtp_item_t         item
);

    logic is_digit;
    logic is_upper;
    logic is_lower;
    logic is_blank;

    always_comb begin
        is_digit = (character >= CH_0) && (character <= CH_9);
        is_upper = (character >= CH_UA) && (character <= CH_UF);
        is_lower = (character >= CH_LA) && (character <= CH_LF);
        is_blank = (character == CH_SPACE) || ((character >= CH_TAB) && (character <= CH_CR));

        item.ends    = is_last | end_only;
        item.no_char = end_only;
        // letters 'A'..'F' and 'a'..'f' both have low nibble 1..6
        item.nibble  = is_digit ? character[NIBBLE_W-1:0]
                                : character[NIBBLE_W-1:0] + NIBBLE_W'(9);

        if (is_digit || is_upper || is_lower) begin
            item.cls = CLS_HEX;
        end else if (is_blank) begin
            item.cls = CLS_BLANK;
        end else if (character == CH_COLON) begin
            item.cls = CLS_COLON;
        end else if (character == CH_DASH) begin
            item.cls = CLS_DASH;
        end else begin
            item.cls = CLS_OTHER;
        end
    end

endmodule

// ----- sv/mtp_queue.sv -----
// ----------------------------------------------------------------------------
// mtp_queue
// Short flop-based queue between the classifier and the parser.
// ----------------------------------------------------------------------------
module mtp_queue
    import mtp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      wr_valid,
    output logic      wr_ready,
    input  mtp_item_t wr_item,
    output logic      rd_valid,
    input  logic      rd_ready,
    output mtp_item_t rd_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    mtp_item_t        mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    logic             pop;

    always_comb begin
        wr_ready = (count_reg != CNT_FULL);
        rd_valid = (count_reg != '0);
        rd_item  = mem_reg[rd_ptr_reg];
        push     = wr_valid && wr_ready;
        pop      = rd_valid && rd_ready;

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

// ----- sv/mtp_parse.sv -----
// ----------------------------------------------------------------------------
// mtp_parse
// Back end: runs the parse state machine and holds the result register.
// ----------------------------------------------------------------------------
module mtp_parse
    import mtp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              item_valid,
    output logic              item_ready,
    input  mtp_item_t         item,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [2:0]        m_error_code,
    output logic [ADDR_W-1:0] m_address
);

    phase_t              phase_reg, phase_next;
    logic [PART_W-1:0]   part_reg, part_next;
    logic [DIGIT_W-1:0]  digits_reg, digits_next;
    sep_kind_t           sep_reg, sep_next;
    logic [ADDR_W-1:0]   acc_reg, acc_next;
    err_code_t           err_reg, err_next;

    logic                m_valid_reg, m_valid_next;
    err_code_t           m_code_reg, m_code_next;
    logic [ADDR_W-1:0]   m_addr_reg, m_addr_next;

    logic                out_free;
    logic                pop;
    phase_t              ph;
    sep_kind_t           kind;
    err_code_t           code;

    // Control: pop an item when its result, if any, has room.
    always_comb begin
        out_free   = !m_valid_reg || m_ready;
        pop        = item_valid && (!item.ends || out_free);
        item_ready = !item.ends || out_free;
    end

    // Next state of the parser.
    always_comb begin
        phase_next  = phase_reg;
        part_next   = part_reg;
        digits_next = digits_reg;
        sep_next    = sep_reg;
        acc_next    = acc_reg;
        err_next    = err_reg;
        ph          = phase_reg;
        kind        = (item.cls == CLS_COLON) ? SEP_COLON : SEP_DASH;

        if (!item.no_char && (err_reg == ERR_NONE)) begin
            // leading blank skipped, anything else starts the first part
            if (ph == PH_LEAD && item.cls != CLS_BLANK) begin
                ph = PH_START;
            end
            case (ph)
                PH_LEAD: begin
                end
                PH_START: begin
                    if (item.cls == CLS_HEX) begin
                        acc_next    = {acc_reg[ADDR_W-NIBBLE_W-1:0], item.nibble};
                        digits_next = DIGIT_W'(1);
                        phase_next  = PH_PART;
                    end else begin
                        err_next = ERR_NO_DIGIT;
                    end
                end
                PH_PART: begin
                    if (item.cls == CLS_HEX) begin
                        if (digits_reg >= DIGITS_PER_PART) begin
                            err_next = ERR_TOO_MANY;
                        end else begin
                            acc_next    = {acc_reg[ADDR_W-NIBBLE_W-1:0], item.nibble};
                            digits_next = digits_reg + DIGIT_W'(1);
                        end
                    end else if ((item.cls == CLS_COLON || item.cls == CLS_DASH)
                                 && digits_reg == DIGITS_PER_PART
                                 && part_reg < LAST_PART) begin
                        if (sep_reg != SEP_NONE && sep_reg != kind) begin
                            err_next = ERR_MIXED_SEP;
                        end else begin
                            sep_next    = kind;
                            part_next   = part_reg + PART_W'(1);
                            digits_next = '0;
                            phase_next  = PH_START;
                        end
                    end else if (item.cls == CLS_BLANK && part_reg == LAST_PART) begin
                        phase_next = PH_TRAIL;
                    end else begin
                        err_next = ERR_UNEXPECTED;
                    end
                end
                PH_TRAIL: begin
                    if (item.cls != CLS_BLANK) begin
                        err_next = ERR_TRAILING;
                    end
                end
                default: begin
                end
            endcase
        end

        code = err_next;
        if (code == ERR_NONE) begin
            if (part_next != LAST_PART) begin
                code = ERR_PART_COUNT;
            end else if (digits_next != DIGITS_PER_PART) begin
                code = ERR_LAST_DIGITS;
            end
        end
    end

    // Result register loads on the closing item; parser state restarts.
    always_comb begin
        m_valid_next = m_valid_reg;
        m_code_next  = m_code_reg;
        m_addr_next  = m_addr_reg;
        if (pop && item.ends) begin
            m_valid_next = 1'b1;
            m_code_next  = code;
            m_addr_next  = (code == ERR_NONE) ? acc_next : '0;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
        m_valid      = m_valid_reg;
        m_error_code = m_code_reg;
        m_address    = m_addr_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_LEAD;
            part_reg    <= '0;
            digits_reg  <= '0;
            sep_reg     <= SEP_NONE;
            acc_reg     <= '0;
            err_reg     <= ERR_NONE;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (pop) begin
                if (item.ends) begin
                    phase_reg  <= PH_LEAD;
                    part_reg   <= '0;
                    digits_reg <= '0;
                    sep_reg    <= SEP_NONE;
                    acc_reg    <= '0;
                    err_reg    <= ERR_NONE;
                end else begin
                    phase_reg  <= phase_next;
                    part_reg   <= part_next;
                    digits_reg <= digits_next;
                    sep_reg    <= sep_next;
                    acc_reg    <= acc_next;
                    err_reg    <= err_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_code_reg <= m_code_next;
        m_addr_reg <= m_addr_next;
    end

endmodule

// ----- sv/mac_address_text_parser.sv -----
// ----------------------------------------------------------------------------
// mac_address_text_parser
// Parses MAC address text one character per item into a 48-bit address.
// ----------------------------------------------------------------------------
//  channel | ports                                          | direction
//  --------+------------------------------------------------+----------
//  input   | s_valid s_ready s_character s_is_last s_end_only | in
//  result  | m_valid m_ready m_error_code m_address           | out
//
//  One character per cycle sustained while results are taken; a character
//  passes the classifier, the queue and the parser. A result is registered
//  once the parser pops its closing item. aresetn clears the queue, the
//  parser and the result valid flag. A stalled result holds only closing
//  items back; the queue takes characters until full (QDEPTH entries).
// ----------------------------------------------------------------------------
module mac_address_text_parser
    import mtp_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [CHAR_W-1:0] s_character,
    input  logic              s_is_last,
    input  logic              s_end_only,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [2:0]        m_error_code,
    output logic [ADDR_W-1:0] m_address
);

    mtp_item_t front_item;
    mtp_item_t back_item;
    logic      back_valid;
    logic      back_ready;

    mtp_classify u_classify (
        .character (s_character),
        .is_last   (s_is_last),
        .end_only  (s_end_only),
        .item      (front_item)
    );

    mtp_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (s_valid),
        .wr_ready (s_ready),
        .wr_item  (front_item),
        .rd_valid (back_valid),
        .rd_ready (back_ready),
        .rd_item  (back_item)
    );

    mtp_parse u_parse (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .item_valid   (back_valid),
        .item_ready   (back_ready),
        .item         (back_item),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_error_code (m_error_code),
        .m_address    (m_address)
    );

endmodule

// ----- dv/mac_address_text_parser_tb.sv -----
// ----------------------------------------------------------------------------
// mac_address_text_parser_tb
// Feeds address strings one character per item, predicts each closing
// result in the bench, and compares error code and address at the output.
// Directed strings, a result stall, random well-formed, damaged, noise text.
// ----------------------------------------------------------------------------
module mac_address_text_parser_tb;
    import mtp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS   = 600;
    localparam int RX_HOLD_CYCLES = 120;
    localparam int DRAIN_CYCLES   = 8;
    localparam int MAX_GAP        = 20;
    localparam int TIMEOUT_NS     = 1_000_000;

    // how a string is closed
    typedef enum int {
        CLOSE_ON_CHAR,    // is_last on the final character
        CLOSE_MARK_LAST,  // extra end_only item with is_last set
        CLOSE_MARK        // extra end_only item with is_last clear
    } close_t;

    typedef struct packed {
        err_code_t         code;
        logic [ADDR_W-1:0] addr;
    } addr_result_t;

    typedef struct {
        string             text;
        close_t            close;
        bit                typed;
        err_code_t         code;
        logic [ADDR_W-1:0] addr;
    } text_row_t;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [CHAR_W-1:0] s_character;
    logic              s_is_last;
    logic              s_end_only;
    logic              m_valid;
    logic              m_ready;
    logic [2:0]        m_error_code;
    logic [ADDR_W-1:0] m_address;

    // typed-in expectation that travels with the offered item
    logic              tag_typed;
    err_code_t         tag_code;
    logic [ADDR_W-1:0] tag_addr;

    int tx_idle_pct;
    int rx_idle_pct;
    int hold_seq;
    int items_sent;
    int fail_count;

    addr_result_t results_due[$];
    text_row_t    text_table[$];

    // parser state as seen by the bench
    phase_t            pr_phase;
    logic [PART_W-1:0] pr_part;
    logic [DIGIT_W-1:0] pr_digits;
    sep_kind_t         pr_sep;
    logic [ADDR_W-1:0] pr_acc;
    err_code_t         pr_err;

    mac_address_text_parser u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_character  (s_character),
        .s_is_last    (s_is_last),
        .s_end_only   (s_end_only),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_error_code (m_error_code),
        .m_address    (m_address)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------
    function automatic bit hex_digit(input logic [CHAR_W-1:0] ch,
                                     output logic [NIBBLE_W-1:0] nib);
        logic [CHAR_W-1:0] v;
        v = '0;
        hex_digit = 1'b1;
        if (ch >= CH_0 && ch <= CH_9)       v = ch - CH_0;
        else if (ch >= CH_UA && ch <= CH_UF) v = ch - CH_UA + 8'd10;
        else if (ch >= CH_LA && ch <= CH_LF) v = ch - CH_LA + 8'd10;
        else hex_digit = 1'b0;
        nib = v[NIBBLE_W-1:0];
    endfunction

    function automatic void clear_parser();
        pr_phase  = PH_LEAD;
        pr_part   = '0;
        pr_digits = '0;
        pr_sep    = SEP_NONE;
        pr_acc    = '0;
        pr_err    = ERR_NONE;
    endfunction

    function automatic void parse_char(input logic [CHAR_W-1:0] ch);
        logic [NIBBLE_W-1:0] nib;
        bit                  is_hex;
        bit                  blank;
        sep_kind_t           kind;
        is_hex = hex_digit(ch, nib);
        blank  = (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);
        if (pr_err != ERR_NONE) return;
        if (pr_phase == PH_LEAD) begin
            if (blank) return;
            pr_phase = PH_START;
        end
        case (pr_phase)
            PH_START: begin
                if (!is_hex) begin
                    pr_err = ERR_NO_DIGIT;
                end else begin
                    pr_acc    = {pr_acc[ADDR_W-NIBBLE_W-1:0], nib};
                    pr_digits = 2'd1;
                    pr_phase  = PH_PART;
                end
            end
            PH_PART: begin
                if (is_hex) begin
                    if (pr_digits >= DIGITS_PER_PART) begin
                        pr_err = ERR_TOO_MANY;
                    end else begin
                        pr_acc    = {pr_acc[ADDR_W-NIBBLE_W-1:0], nib};
                        pr_digits = pr_digits + 2'd1;
                    end
                end else if ((ch == CH_COLON || ch == CH_DASH) &&
                             pr_digits == DIGITS_PER_PART && pr_part < LAST_PART) begin
                    kind = (ch == CH_COLON) ? SEP_COLON : SEP_DASH;
                    if (pr_sep == SEP_NONE) pr_sep = kind;
                    if (pr_sep != kind) begin
                        pr_err = ERR_MIXED_SEP;
                    end else begin
                        pr_part   = pr_part + 3'd1;
                        pr_digits = '0;
                        pr_phase  = PH_START;
                    end
                end else if (blank && pr_part == LAST_PART) begin
                    pr_phase = PH_TRAIL;
                end else begin
                    pr_err = ERR_UNEXPECTED;
                end
            end
            default: begin
                if (!blank) pr_err = ERR_TRAILING;
            end
        endcase
    endfunction

    // One accepted item; due is set when the item closes the string.
    function automatic void parse_item(input logic [CHAR_W-1:0] ch, input logic last,
                                       input logic eo, output logic due,
                                       output err_code_t code,
                                       output logic [ADDR_W-1:0] addr);
        if (!eo) parse_char(ch);
        due  = last || eo;
        code = ERR_NONE;
        addr = '0;
        if (due) begin
            code = pr_err;
            if (code == ERR_NONE) begin
                if (pr_part != LAST_PART) code = ERR_PART_COUNT;
                else if (pr_digits != DIGITS_PER_PART) code = ERR_LAST_DIGITS;
            end
            addr = (code == ERR_NONE) ? pr_acc : '0;
            clear_parser();
        end
    endfunction

    // ------------------------------------------------------------------
    // scoreboard: predict on input handshakes, compare on output ones
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : scoreboard
        logic              due;
        err_code_t         got_code;
        logic [ADDR_W-1:0] got_addr;
        addr_result_t      want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                parse_item(s_character, s_is_last, s_end_only, due, got_code, got_addr);
                if (due) begin
                    if (tag_typed) begin
                        got_code = tag_code;
                        got_addr = tag_addr;
                    end
                    results_due.push_back('{code: got_code, addr: got_addr});
                end
            end
            if (m_valid && m_ready) begin
                if (results_due.size() == 0) begin
                    $display("%0t: unexpected result: error_code %0d address %h",
                             $time, m_error_code, m_address);
                    fail_count++;
                end else begin
                    want = results_due.pop_front();
                    if (m_error_code !== want.code) begin
                        $display("%0t: error_code mismatch: expected %0d actual %0d",
                                 $time, want.code, m_error_code);
                        fail_count++;
                    end
                    if (m_address !== want.addr) begin
                        $display("%0t: address mismatch: expected %h actual %h",
                                 $time, want.addr, m_address);
                        fail_count++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // result side: random stalls plus long hold-offs on request
    // ------------------------------------------------------------------
    initial begin : result_sink
        int hold_count;
        int hold_seen;
        hold_count = 0;
        hold_seen  = 0;
        forever begin
            @(posedge aclk);
            if (hold_seq != hold_seen) begin
                hold_seen  = hold_seq;
                hold_count = RX_HOLD_CYCLES;
            end
            if (hold_count > 0) begin
                hold_count--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // character side
    // ------------------------------------------------------------------
    task automatic offer_item(input logic [CHAR_W-1:0] ch, input logic last,
                              input logic eo, input bit typed, input err_code_t code,
                              input logic [ADDR_W-1:0] addr);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < tx_idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_character <= ch;
        s_is_last   <= last;
        s_end_only  <= eo;
        tag_typed   <= typed;
        tag_code    <= code;
        tag_addr    <= addr;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic send_text(ref logic [CHAR_W-1:0] txt[$], input close_t close,
                             input bit typed, input err_code_t code,
                             input logic [ADDR_W-1:0] addr);
        int n;
        n = txt.size();
        for (int i = 0; i < n; i++)
            offer_item(txt[i], (close == CLOSE_ON_CHAR) && (i == n - 1), 1'b0,
                       typed, code, addr);
        if (close != CLOSE_ON_CHAR || n == 0)
            offer_item(CHAR_W'($urandom_range(255)), close != CLOSE_MARK, 1'b1,
                       typed, code, addr);
    endtask

    // Hold the input until every predicted result has been taken.
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (results_due.size() != 0) @(posedge aclk);
    endtask

    function automatic void add_row(input string text, input close_t close,
                                    input bit typed, input err_code_t code,
                                    input logic [ADDR_W-1:0] addr);
        text_table.push_back('{text: text, close: close, typed: typed,
                               code: code, addr: addr});
    endfunction

    function automatic logic [CHAR_W-1:0] any_blank();
        return ($urandom_range(5) == 0) ? CH_SPACE
                                        : CHAR_W'(CH_TAB + $urandom_range(4));
    endfunction

    function automatic logic [CHAR_W-1:0] any_hex();
        int v;
        v = $urandom_range(15);
        if (v < 10) return CHAR_W'(CH_0 + v);
        return CHAR_W'(($urandom_range(1) ? CH_UA : CH_LA) + (v - 10));
    endfunction

    task automatic make_text(ref logic [CHAR_W-1:0] txt[$], output close_t close);
        int                kind;
        int                pos;
        logic [CHAR_W-1:0] sep;
        txt.delete();
        kind = $urandom_range(99);
        sep  = $urandom_range(1) ? CH_COLON : CH_DASH;
        repeat ($urandom_range(3)) txt.push_back(any_blank());
        for (int p = 0; p < 6; p++) begin
            txt.push_back(any_hex());
            txt.push_back(any_hex());
            if (p < 5) txt.push_back(sep);
        end
        repeat ($urandom_range(3)) txt.push_back(any_blank());
        if (kind >= 55 && kind < 80) begin
            // damage one spot: replace, drop or insert
            pos = $urandom_range(txt.size() - 1);
            case ($urandom_range(5))
                0: txt[pos] = CHAR_W'($urandom_range(255));
                1: txt[pos] = (sep == CH_COLON) ? CH_DASH : CH_COLON;
                2: txt[pos] = any_blank();
                3: txt[pos] = any_hex();
                4: txt.delete(pos);
                default: txt.insert(pos, $urandom_range(1) ? any_hex() : sep);
            endcase
        end else if (kind >= 80 && kind < 90) begin
            repeat ($urandom_range(txt.size())) void'(txt.pop_back());
        end else if (kind >= 90) begin
            txt.delete();
            repeat ($urandom_range(20)) txt.push_back(CHAR_W'($urandom_range(255)));
        end
        case ($urandom_range(9))
            6, 7:    close = CLOSE_MARK_LAST;
            8, 9:    close = CLOSE_MARK;
            default: close = CLOSE_ON_CHAR;
        endcase
        if (txt.size() == 0 && close == CLOSE_ON_CHAR) close = CLOSE_MARK_LAST;
    endtask

    initial begin : stimulus
        logic [CHAR_W-1:0] txt[$];
        close_t            close;
        int                stage;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_character = '0;
        s_is_last   = 1'b0;
        s_end_only  = 1'b0;
        m_ready     = 1'b0;
        tag_typed   = 1'b0;
        tag_code    = ERR_NONE;
        tag_addr    = '0;
        tx_idle_pct = 34;
        rx_idle_pct = 53;
        hold_seq    = 0;
        items_sent  = 0;
        fail_count  = 0;
        clear_parser();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        add_row("", CLOSE_MARK_LAST, 1, ERR_PART_COUNT, '0);
        add_row("", CLOSE_MARK, 1, ERR_PART_COUNT, '0);
        add_row(" \011\012\013\014\015", CLOSE_ON_CHAR, 1, ERR_PART_COUNT, '0);
        add_row("00:00:00:00:00:00", CLOSE_ON_CHAR, 1, ERR_NONE, '0);
        add_row("ff-FF-fF-Ff-ff-FF", CLOSE_ON_CHAR, 1, ERR_NONE, 48'hffff_ffff_ffff);
        add_row("  01:23:45:67:89:ab \011", CLOSE_MARK, 1, ERR_NONE, 48'h0123_4567_89ab);
        add_row("\015Ab:cD:eF:a9:B0:c2\012", CLOSE_ON_CHAR, 0, ERR_NONE, '0);
        add_row("g1:22:33:44:55:66", CLOSE_ON_CHAR, 1, ERR_NO_DIGIT, '0);
        add_row("\200", CLOSE_ON_CHAR, 1, ERR_NO_DIGIT, '0);
        add_row("123:45:67:89:ab:cd", CLOSE_ON_CHAR, 1, ERR_TOO_MANY, '0);
        add_row("01:02-03:04:05:06", CLOSE_ON_CHAR, 1, ERR_MIXED_SEP, '0);
        add_row("01-02-03-04-05-06 \377", CLOSE_ON_CHAR, 1, ERR_TRAILING, '0);
        add_row("01-02-03-04-05-06 x", CLOSE_MARK_LAST, 0, ERR_NONE, '0);
        add_row("0:11:22:33:44:55", CLOSE_ON_CHAR, 1, ERR_UNEXPECTED, '0);
        add_row("01:02:03:04:05:06:", CLOSE_ON_CHAR, 1, ERR_UNEXPECTED, '0);
        add_row("01:02:03 04:05:06", CLOSE_ON_CHAR, 1, ERR_UNEXPECTED, '0);
        add_row("01:02:03:04:05:6 ", CLOSE_ON_CHAR, 1, ERR_LAST_DIGITS, '0);
        add_row("01:02:03:04:05:6", CLOSE_ON_CHAR, 1, ERR_LAST_DIGITS, '0);
        add_row("01:02:03:04:05", CLOSE_ON_CHAR, 1, ERR_PART_COUNT, '0);
        add_row("01::02:03:04:05:06", CLOSE_ON_CHAR, 1, ERR_NO_DIGIT, '0);
        add_row("-01:02:03:04:05:06", CLOSE_ON_CHAR, 0, ERR_NONE, '0);
        add_row("9f:e0:3c:5d:7a:1b", CLOSE_MARK_LAST, 0, ERR_NONE, '0);
        add_row("01:02:03:04:05:06\012\012\012", CLOSE_ON_CHAR, 0, ERR_NONE, '0);

        foreach (text_table[r]) begin
            txt.delete();
            for (int i = 0; i < text_table[r].text.len(); i++)
                txt.push_back(text_table[r].text[i]);
            send_text(txt, text_table[r].close, text_table[r].typed,
                      text_table[r].code, text_table[r].addr);
        end
        wait_drained();

        // stall the result side while closing items keep coming
        tx_idle_pct = 0;
        hold_seq   <= hold_seq + 1;
        for (int k = 0; k < 12; k++) begin
            txt.delete();
            if (k % 3 == 2)
                for (int i = 0; i < 6; i++) begin
                    txt.push_back(any_hex());
                    txt.push_back(any_hex());
                    if (i < 5) txt.push_back(CH_COLON);
                end
            send_text(txt, (txt.size() == 0) ? CLOSE_MARK_LAST : CLOSE_ON_CHAR,
                      0, ERR_NONE, '0);
        end
        wait_drained();

        items_sent = 0;
        stage      = -1;
        while (items_sent < RANDOM_ITEMS) begin
            if (items_sent * 3 / RANDOM_ITEMS != stage) begin
                stage = items_sent * 3 / RANDOM_ITEMS;
                case (stage)
                    0:       begin tx_idle_pct = 34; rx_idle_pct = 53; end
                    1:       begin tx_idle_pct = 53; rx_idle_pct = 34; end
                    default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
                endcase
            end
            make_text(txt, close);
            send_text(txt, close, 0, ERR_NONE, '0);
        end
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("simulation failed");
        $finish;
    end

endmodule
